FILE: rtl/core/pfic_pkg.sv
package pfic_pkg;

  localparam int unsigned POINT_COUNT       = 4096;
  localparam int unsigned MAX_POLY_VERTICES = 32;
  localparam int unsigned FAN_MIN_VERTS     = 3;

  localparam int unsigned PT_W   = 12;
  localparam int unsigned SIZE_W = 6;
  localparam int unsigned USED_W = 13;

  localparam int unsigned ADDR_W  = $clog2(POINT_COUNT);
  localparam int unsigned DENSE_W = $clog2(POINT_COUNT + 1);
  localparam int unsigned POS_W   = $clog2(MAX_POLY_VERTICES + 1);
  localparam int unsigned CMP_W   = (SIZE_W > POS_W) ? SIZE_W : POS_W;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_WIPE,
    ST_IDLE,
    ST_LOOKUP,
    ST_CLR_RESULT
  } pfic_state_e;

  typedef struct packed {
    logic ready;
    logic accept;
    logic sweep;
    logic commit;
    logic clear_result;
  } pfic_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic sweep_last;
    logic out_free;
  } pfic_status_t;

endpackage

FILE: rtl/core/pfic_ctrl.sv
module pfic_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  pfic_pkg::pfic_status_t status_i,
  output pfic_pkg::pfic_cmd_t    cmd_o
);
  import pfic_pkg::*;

  pfic_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_WIPE: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_CLR_RESULT;
        end
      end
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (status_i.op_clear) ? ST_WIPE : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CLR_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.clear_result = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

FILE: rtl/core/pfic_datapath.sv
module pfic_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfic_pkg::pfic_cmd_t              cmd_i,
  output pfic_pkg::pfic_status_t           status_o,
  input  logic                            opcode_i,
  input  logic [pfic_pkg::PT_W-1:0]       point_index_i,
  input  logic                            first_vertex_i,
  input  logic [pfic_pkg::SIZE_W-1:0]     polygon_size_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic                            triangle_valid_o,
  output logic [pfic_pkg::PT_W-1:0]       corner_a_o,
  output logic [pfic_pkg::PT_W-1:0]       corner_b_o,
  output logic [pfic_pkg::PT_W-1:0]       corner_c_o,
  output logic                            new_point_valid_o,
  output logic [pfic_pkg::PT_W-1:0]       source_point_o,
  output logic [pfic_pkg::PT_W-1:0]       dense_index_o,
  output logic [pfic_pkg::USED_W-1:0]     used_points_o
);
  import pfic_pkg::*;

  localparam logic [ADDR_W-1:0]  LastAddr  = ADDR_W'(POINT_COUNT - 1);
  localparam logic [DENSE_W-1:0] DenseMax  = DENSE_W'(POINT_COUNT);
  localparam logic [CMP_W-1:0]   MaxVerts  = CMP_W'(MAX_POLY_VERTICES);
  localparam logic [CMP_W-1:0]   MinVerts  = CMP_W'(FAN_MIN_VERTS);
  localparam logic [CMP_W-1:0]   TwoVerts  = CMP_W'(2);

  // entry: {valid, dense index}
  logic [ADDR_W:0] mem [POINT_COUNT];
  logic [ADDR_W:0] rd_q;

  logic [ADDR_W-1:0]  sweep_q, sweep_d;
  logic [DENSE_W-1:0] next_dense_q, next_dense_d;
  logic [ADDR_W-1:0]  fan_anchor_q, fan_anchor_d;
  logic [ADDR_W-1:0]  fan_prev_q, fan_prev_d;
  logic [POS_W-1:0]   vpos_q, vpos_d;

  logic [ADDR_W-1:0]  pt_q;
  logic               active_q, k_is0_q, k_ge2_q;

  logic [CMP_W-1:0]   size_ext, size_lim, k;
  logic               active, k_is0, k_ge2;

  logic               fresh;
  logic [ADDR_W-1:0]  dense;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W:0]    mem_wdata;

  logic               out_valid_q, out_valid_d;
  logic               tri_q, newpt_q;
  logic [PT_W-1:0]    ca_q, cb_q, cc_q, src_q, dense_out_q;
  logic [USED_W-1:0]  used_q;
  logic               out_free;

  assign size_ext = CMP_W'(polygon_size_i);
  assign size_lim = (size_ext > MaxVerts) ? MaxVerts : size_ext;
  assign k        = first_vertex_i ? '0 : CMP_W'(vpos_q);
  assign active   = (size_lim >= MinVerts) && (k < size_lim);
  assign k_is0    = (k == '0);
  assign k_ge2    = (k >= TwoVerts);

  assign fresh = !rd_q[ADDR_W];
  assign dense = fresh ? next_dense_q[ADDR_W-1:0] : rd_q[ADDR_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.op_clear   = (opcode_i == OP_CLEAR);
  assign status_o.sweep_last = (sweep_q == LastAddr);
  assign status_o.out_free   = out_free;

  always_comb begin
    sweep_d      = sweep_q;
    next_dense_d = next_dense_q;
    fan_anchor_d = fan_anchor_q;
    fan_prev_d   = fan_prev_q;
    vpos_d       = vpos_q;
    mem_we       = 1'b0;
    mem_waddr    = sweep_q;
    mem_wdata    = '0;
    if (cmd_i.sweep) begin
      mem_we  = 1'b1;
      sweep_d = (sweep_q == LastAddr) ? '0 : sweep_q + 1'b1;
    end
    if (cmd_i.accept) begin
      if (opcode_i == OP_CLEAR) begin
        next_dense_d = '0;
        fan_anchor_d = '0;
        fan_prev_d   = '0;
        vpos_d       = '0;
      end else begin
        vpos_d = (k < MaxVerts) ? POS_W'(k + 1'b1) : POS_W'(MAX_POLY_VERTICES);
      end
    end
    if (cmd_i.commit && active_q) begin
      if (fresh) begin
        mem_we    = 1'b1;
        mem_waddr = pt_q;
        mem_wdata = {1'b1, dense};
        if (next_dense_q < DenseMax) begin
          next_dense_d = next_dense_q + 1'b1;
        end
      end
      if (k_is0_q) begin
        fan_anchor_d = dense;
      end
      fan_prev_d = dense;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[point_index_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= '0;
      next_dense_q <= '0;
      fan_anchor_q <= '0;
      fan_prev_q   <= '0;
      vpos_q       <= '0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      sweep_q      <= sweep_d;
      next_dense_q <= next_dense_d;
      fan_anchor_q <= fan_anchor_d;
      fan_prev_q   <= fan_prev_d;
      vpos_q       <= vpos_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.accept) begin
        active_q <= active && (opcode_i == OP_VERTEX);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pt_q    <= point_index_i;
      k_is0_q <= k_is0;
      k_ge2_q <= k_ge2;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.commit || cmd_i.clear_result) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      tri_q       <= active_q && k_ge2_q;
      ca_q        <= (active_q && k_ge2_q) ? fan_anchor_q : '0;
      cb_q        <= (active_q && k_ge2_q) ? fan_prev_q : '0;
      cc_q        <= (active_q && k_ge2_q) ? dense : '0;
      newpt_q     <= active_q && fresh;
      src_q       <= (active_q && fresh) ? pt_q : '0;
      dense_out_q <= (active_q && fresh) ? dense : '0;
      used_q      <= USED_W'(next_dense_d);
    end else if (cmd_i.clear_result) begin
      tri_q       <= 1'b0;
      ca_q        <= '0;
      cb_q        <= '0;
      cc_q        <= '0;
      newpt_q     <= 1'b0;
      src_q       <= '0;
      dense_out_q <= '0;
      used_q      <= '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign triangle_valid_o  = tri_q;
  assign corner_a_o        = ca_q;
  assign corner_b_o        = cb_q;
  assign corner_c_o        = cc_q;
  assign new_point_valid_o = newpt_q;
  assign source_point_o    = src_q;
  assign dense_index_o     = dense_out_q;
  assign used_points_o     = used_q;

`ifndef NO_ASSERTIONS
  a_dense_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_dense_q <= DenseMax)
    else $error("dense counter beyond point count");

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.accept, cmd_i.sweep, cmd_i.commit, cmd_i.clear_result}))
    else $error("conflicting datapath commands");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit || cmd_i.clear_result) |-> out_free)
    else $error("result loaded over a pending beat");

  a_fresh_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && active_q && fresh && next_dense_q < DenseMax)
      |=> next_dense_q == $past(next_dense_q) + 1'b1)
    else $error("new point did not advance dense counter");

  a_sweep_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep |-> !cmd_i.ready)
    else $error("input taken during table sweep");
`endif

endmodule

FILE: rtl/core/polygon_fan_index_compactor.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  opcode, point_index, first_vertex, polygon_size
// out      output     out_valid_o / out_stall_i triangle, corners, new point, used_points
//
// A vertex beat is accepted with a table read, then looked up, with table write and
// result load once the output register has room.
// After reset the table valid bits are wiped with in_stall_o high.
// A clear beat runs the same wipe before its result is loaded.
// The output register holds a result under out_stall_i; a new beat is taken meanwhile.
module polygon_fan_index_compactor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [pfic_pkg::PT_W-1:0]   point_index_i,
  input  logic                        first_vertex_i,
  input  logic [pfic_pkg::SIZE_W-1:0] polygon_size_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        triangle_valid_o,
  output logic [pfic_pkg::PT_W-1:0]   corner_a_o,
  output logic [pfic_pkg::PT_W-1:0]   corner_b_o,
  output logic [pfic_pkg::PT_W-1:0]   corner_c_o,
  output logic                        new_point_valid_o,
  output logic [pfic_pkg::PT_W-1:0]   source_point_o,
  output logic [pfic_pkg::PT_W-1:0]   dense_index_o,
  output logic [pfic_pkg::USED_W-1:0] used_points_o
);
  import pfic_pkg::*;

  pfic_cmd_t    cmd;
  pfic_status_t status;

  pfic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfic_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .opcode_i          (opcode_i),
    .point_index_i     (point_index_i),
    .first_vertex_i    (first_vertex_i),
    .polygon_size_i    (polygon_size_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .triangle_valid_o  (triangle_valid_o),
    .corner_a_o        (corner_a_o),
    .corner_b_o        (corner_b_o),
    .corner_c_o        (corner_c_o),
    .new_point_valid_o (new_point_valid_o),
    .source_point_o    (source_point_o),
    .dense_index_o     (dense_index_o),
    .used_points_o     (used_points_o)
  );

  assign in_stall_o = !cmd.ready;

endmodule

FILE: bench/fan_result_checker.sv
`timescale 1ns / 1ps

module fan_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        opcode_i,
  input  logic [pfic_pkg::PT_W-1:0]   point_index_i,
  input  logic                        first_vertex_i,
  input  logic [pfic_pkg::SIZE_W-1:0] polygon_size_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic                        triangle_valid_i,
  input  logic [pfic_pkg::PT_W-1:0]   corner_a_i,
  input  logic [pfic_pkg::PT_W-1:0]   corner_b_i,
  input  logic [pfic_pkg::PT_W-1:0]   corner_c_i,
  input  logic                        new_point_valid_i,
  input  logic [pfic_pkg::PT_W-1:0]   source_point_i,
  input  logic [pfic_pkg::PT_W-1:0]   dense_index_i,
  input  logic [pfic_pkg::USED_W-1:0] used_points_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);
  import pfic_pkg::*;

  typedef struct packed {
    logic              triangle;
    logic [PT_W-1:0]   corner_a;
    logic [PT_W-1:0]   corner_b;
    logic [PT_W-1:0]   corner_c;
    logic              new_point;
    logic [PT_W-1:0]   source_point;
    logic [PT_W-1:0]   dense_index;
    logic [USED_W-1:0] used_points;
  } fan_result_t;

  fan_result_t       fan_results_q[$];
  logic [PT_W-1:0]   dense_of [POINT_COUNT];
  bit                point_seen [POINT_COUNT];
  logic [USED_W-1:0] next_dense;
  logic [PT_W-1:0]   fan_anchor;
  logic [PT_W-1:0]   fan_previous;
  int unsigned       vertex_pos;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       checked;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;

  function automatic string fmt_result(fan_result_t r);
    return $sformatf("tri=%0b a=%0d b=%0d c=%0d new=%0b src=%0d dns=%0d used=%0d",
                     r.triangle, r.corner_a, r.corner_b, r.corner_c,
                     r.new_point, r.source_point, r.dense_index, r.used_points);
  endfunction

  function automatic fan_result_t predict_fan_step(logic op, logic [PT_W-1:0] pt, logic first,
                                                   logic [SIZE_W-1:0] size_in);
    fan_result_t       r;
    int unsigned       size;
    int unsigned       k;
    logic [USED_W-1:0] d;
    r = '0;
    if (op == OP_CLEAR) begin
      foreach (point_seen[i]) point_seen[i] = 1'b0;
      next_dense   = '0;
      fan_anchor   = '0;
      fan_previous = '0;
      vertex_pos   = 0;
      return r;
    end
    size = (size_in > MAX_POLY_VERTICES) ? MAX_POLY_VERTICES : size_in;
    k = first ? 0 : vertex_pos;
    vertex_pos = (k < MAX_POLY_VERTICES) ? k + 1 : MAX_POLY_VERTICES;
    if (size >= FAN_MIN_VERTS && k < size) begin
      if (point_seen[pt]) begin
        d = USED_W'(dense_of[pt]);
      end else begin
        d = next_dense;
        dense_of[pt]   = d[PT_W-1:0];
        point_seen[pt] = 1'b1;
        if (next_dense < POINT_COUNT) next_dense = next_dense + 1'b1;
        r.new_point    = 1'b1;
        r.source_point = pt;
        r.dense_index  = d[PT_W-1:0];
      end
      if (k >= 2) begin
        r.triangle = 1'b1;
        r.corner_a = fan_anchor;
        r.corner_b = fan_previous;
        r.corner_c = d[PT_W-1:0];
      end
      if (k == 0) fan_anchor = d[PT_W-1:0];
      fan_previous = d[PT_W-1:0];
    end
    r.used_points = next_dense;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    fan_result_t want;
    fan_result_t got;
    if (!rst_ni) begin
      fan_results_q.delete();
      foreach (point_seen[i]) point_seen[i] = 1'b0;
      next_dense   = '0;
      fan_anchor   = '0;
      fan_previous = '0;
      vertex_pos   = 0;
      fail_count   = 0;
      checked      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{triangle_valid_i, corner_a_i, corner_b_i, corner_c_i,
                new_point_valid_i, source_point_i, dense_index_i, used_points_i};
        if (fan_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat %s", $realtime, fmt_result(got));
        end else begin
          want = fan_results_q.pop_front();
          checked++;
          if (got.triangle !== want.triangle || got.corner_a !== want.corner_a ||
              got.corner_b !== want.corner_b || got.corner_c !== want.corner_c ||
              got.new_point !== want.new_point || got.source_point !== want.source_point ||
              got.dense_index !== want.dense_index || got.used_points !== want.used_points) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result %0d expected %s", $realtime, checked, fmt_result(want));
              $display("%0t: result %0d actual   %s", $realtime, checked, fmt_result(got));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        fan_results_q.push_back(predict_fan_step(opcode_i, point_index_i, first_vertex_i,
                                                 polygon_size_i));
    end
    pending = fan_results_q.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pfic_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1700;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 240;
  localparam int unsigned DRAIN_CYCLES   = 16;

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic              opcode_i       = OP_VERTEX;
  logic [PT_W-1:0]   point_index_i  = '0;
  logic              first_vertex_i = 1'b0;
  logic [SIZE_W-1:0] polygon_size_i = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic              triangle_valid_o;
  logic [PT_W-1:0]   corner_a_o;
  logic [PT_W-1:0]   corner_b_o;
  logic [PT_W-1:0]   corner_c_o;
  logic              new_point_valid_o;
  logic [PT_W-1:0]   source_point_o;
  logic [PT_W-1:0]   dense_index_o;
  logic [USED_W-1:0] used_points_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned idle_cycles = 0;
  int unsigned hold_req    = 0;
  int unsigned vertex_beats;
  int unsigned clear_beats;
  bit          steady_tx;
  logic [PT_W-1:0] pool_base;

  polygon_fan_index_compactor dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .point_index_i     (point_index_i),
    .first_vertex_i    (first_vertex_i),
    .polygon_size_i    (polygon_size_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .triangle_valid_o  (triangle_valid_o),
    .corner_a_o        (corner_a_o),
    .corner_b_o        (corner_b_o),
    .corner_c_o        (corner_c_o),
    .new_point_valid_o (new_point_valid_o),
    .source_point_o    (source_point_o),
    .dense_index_o     (dense_index_o),
    .used_points_o     (used_points_o)
  );

  fan_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .point_index_i     (point_index_i),
    .first_vertex_i    (first_vertex_i),
    .polygon_size_i    (polygon_size_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .triangle_valid_i  (triangle_valid_o),
    .corner_a_i        (corner_a_o),
    .corner_b_i        (corner_b_o),
    .corner_c_i        (corner_c_o),
    .new_point_valid_i (new_point_valid_o),
    .source_point_i    (source_point_o),
    .dense_index_i     (dense_index_o),
    .used_points_i     (used_points_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random wait after each beat, one long hold-off on request
  initial begin : receiver
    int unsigned wait_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    bit          steady_rx;
    wait_left = 0;
    hold_left = 0;
    hold_seen = 0;
    steady_rx = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if ($urandom_range(0, 39) == 0) steady_rx = !steady_rx;
        wait_left = steady_rx ? 0 : $urandom_range(0, 8);
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic op, input logic [PT_W-1:0] pt, input logic first,
                           input logic [SIZE_W-1:0] size);
    int unsigned gap;
    gap = steady_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    point_index_i  <= pt;
    first_vertex_i <= first;
    polygon_size_i <= size;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_CLEAR) clear_beats++;
    else vertex_beats++;
  endtask

  function automatic logic [PT_W-1:0] pick_point();
    if ($urandom_range(0, 9) < 7) return pool_base + PT_W'($urandom_range(0, 47));
    return PT_W'($urandom);
  endfunction

  task automatic send_polygon(input int unsigned size, input int unsigned count, input bit mark);
    for (int unsigned i = 0; i < count; i++)
      send_beat(OP_VERTEX, pick_point(), (i == 0) ? mark : 1'b0, SIZE_W'(size));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned counted;
    int unsigned pick;
    int unsigned size;
    int unsigned count;
    bit          hold_done;
    bit          pause_done;
    counted      = 0;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    vertex_beats = 0;
    clear_beats  = 0;
    steady_tx    = 1'b0;
    pool_base    = PT_W'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // polygon continued without a start mark after reset
    send_beat(OP_VERTEX, 12'd0,    1'b0, 6'd4);
    send_beat(OP_VERTEX, 12'd4095, 1'b0, 6'd4);
    send_beat(OP_VERTEX, 12'd0,    1'b0, 6'd4);
    send_beat(OP_VERTEX, 12'd5,    1'b0, 6'd4);
    // extra vertex past the polygon size
    send_beat(OP_VERTEX, 12'd6,    1'b0, 6'd4);
    // polygons too small to fan
    send_beat(OP_VERTEX, 12'd7,    1'b1, 6'd0);
    send_beat(OP_VERTEX, 12'd8,    1'b1, 6'd1);
    send_beat(OP_VERTEX, 12'd9,    1'b0, 6'd2);
    // size field above and at the vertex limit
    send_beat(OP_VERTEX, 12'd4095, 1'b1, 6'd63);
    send_beat(OP_VERTEX, 12'd100,  1'b0, 6'd63);
    send_beat(OP_VERTEX, 12'd200,  1'b0, 6'd63);
    send_beat(OP_VERTEX, 12'h800,  1'b1, 6'd32);
    send_beat(OP_VERTEX, 12'h7FF,  1'b0, 6'd32);
    send_beat(OP_VERTEX, 12'hAAA,  1'b0, 6'd32);
    send_beat(OP_VERTEX, 12'h555,  1'b0, 6'd32);
    // clear with every other field set high
    send_beat(OP_CLEAR,  12'd4095, 1'b1, 6'd63);
    send_beat(OP_VERTEX, 12'd1,    1'b0, 6'd3);
    send_beat(OP_VERTEX, 12'd2,    1'b0, 6'd3);
    send_beat(OP_VERTEX, 12'd3,    1'b0, 6'd3);
    send_beat(OP_CLEAR,  12'd0,    1'b0, 6'd0);
    drain_results();

    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) steady_tx = !steady_tx;
      if (!hold_done && counted >= 600) begin
        hold_req <= hold_req + 1;
        hold_done = 1'b1;
      end
      if (!pause_done && counted >= 1200) begin
        drain_results();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_beat(OP_CLEAR, PT_W'($urandom), 1'($urandom), SIZE_W'($urandom));
        pool_base = PT_W'($urandom);
        counted++;
      end else if (pick < 80) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 32) : $urandom_range(3, 8);
        send_polygon(size, size, 1'b1);
        counted += size;
      end else if (pick < 88) begin
        size  = $urandom_range(3, 12);
        count = $urandom_range(1, size + 3);
        send_polygon(size, count, 1'($urandom_range(0, 1)));
        counted += (count < size) ? count : size;
      end else if (pick < 94) begin
        send_polygon($urandom_range(0, 2), $urandom_range(1, 3), 1'b1);
      end else begin
        count = $urandom_range(3, 36);
        send_polygon($urandom_range(33, 63), count, 1'b1);
        counted += (count < MAX_POLY_VERTICES) ? count : MAX_POLY_VERTICES;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d vertex beats and %0d clear beats; %0d results compared.",
             vertex_beats, clear_beats, checked);
    $display("Covered fan polygons up to the size limit, broken and tiny polygons, clears,");
    $display("one long result hold-off and one sender pause until drained.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: polygon_fan_index_compactor.f
rtl/core/pfic_pkg.sv
rtl/core/pfic_ctrl.sv
rtl/core/pfic_datapath.sv
rtl/core/polygon_fan_index_compactor.sv
bench/fan_result_checker.sv
bench/tb_top.sv
